// File: sv/cpas_pkg.sv
// package: shared constants, mode codes and ray direction tables for the attack generator
`timescale 1ns / 1ps

package cpas_pkg;

  localparam int SqW    = 6;
  localparam int BoardW = 64;
  localparam int ModeW  = 2;

  // slave tdata: piece_set, origin_square, blockers, padded to whole bytes
  localparam int InDataW = 136;
  localparam int OutDataW = 64;

  localparam logic [ModeW-1:0] MODE_KNIGHT = 2'd0;
  localparam logic [ModeW-1:0] MODE_KING   = 2'd1;
  localparam logic [ModeW-1:0] MODE_BISHOP = 2'd2;
  localparam logic [ModeW-1:0] MODE_ROOK   = 2'd3;

  localparam logic [BoardW-1:0] NOT_FILE_A  = 64'hFEFE_FEFE_FEFE_FEFE;
  localparam logic [BoardW-1:0] NOT_FILE_H  = 64'h7F7F_7F7F_7F7F_7F7F;
  localparam logic [BoardW-1:0] NOT_FILE_AB = 64'hFCFC_FCFC_FCFC_FCFC;
  localparam logic [BoardW-1:0] NOT_FILE_GH = 64'h3F3F_3F3F_3F3F_3F3F;

  localparam int NumDirs  = 8;
  localparam int RayLen   = 7;

  // first four directions are diagonal, last four orthogonal
  localparam logic signed [1:0] RAY_DR [NumDirs] = '{
    2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0
  };
  localparam logic signed [1:0] RAY_DF [NumDirs] = '{
    2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1
  };

endpackage

// File: sv/chess_piece_attack_set.sv
// top level: streaming bitboard attack generator for knights, kings, bishops and rooks
`timescale 1ns / 1ps

// usage
//   slave channel s_*: one request word per handshake; tuser carries the mode
//   (knight, king, bishop rays, rook rays), tdata the piece set, origin square
//   and blocker bitboard
//   master channel m_*: one attack bitboard word per request, in request order
// dataflow and throughput
//   a request is held in the input register and moves to the result register
//   when that is free; one request per cycle while m_tready is high; the work
//   is one pass of shift/mask logic plus seven-square ray walks between them
// reset
//   rst clears both valid flags; no request or result survives it
// stall
//   while m_tready is low the result register holds; the input register still
//   takes one more word, and s_tready falls only when both stages are full
module chess_piece_attack_set (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [63:0] piece_set, [69:64] origin_square, [133:70] blockers, [135:134] zero
  input  logic [cpas_pkg::InDataW-1:0]  s_tdata,
  // [1:0] mode
  input  logic [cpas_pkg::ModeW-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [63:0] attack_set
  output logic [cpas_pkg::OutDataW-1:0] m_tdata
);

  // input stage
  logic                          in_valid;
  logic [cpas_pkg::ModeW-1:0]    mode;
  logic [cpas_pkg::BoardW-1:0]   piece_set;
  logic [cpas_pkg::SqW-1:0]      origin_square;
  logic [cpas_pkg::BoardW-1:0]   blockers;

  // result stage
  logic                          out_valid;
  logic [cpas_pkg::BoardW-1:0]   attack_set;
  logic [cpas_pkg::BoardW-1:0]   attack_set_next;

  logic                          out_free;
  logic                          move;

  assign out_free = !out_valid || m_tready;
  assign move     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  cpas_attack u_attack (
    .mode          (mode),
    .piece_set     (piece_set),
    .origin_square (origin_square),
    .blockers      (blockers),
    .attack_set    (attack_set_next)
  );

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  // request payload, captured on each accepted word
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mode          <= s_tuser;
      piece_set     <= s_tdata[63:0];
      origin_square <= s_tdata[69:64];
      blockers      <= s_tdata[133:70];
    end
  end

  // result payload advances when the input register holds a request and the result register is free
  always_ff @(posedge clk) begin
    if (move) begin
      attack_set <= attack_set_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = attack_set;

endmodule

// File: sv/cpas_attack.sv
// combinational attack set logic for leaper and slider requests
`timescale 1ns / 1ps

module cpas_attack (
  input  logic [cpas_pkg::ModeW-1:0]  mode,
  input  logic [cpas_pkg::BoardW-1:0] piece_set,
  input  logic [cpas_pkg::SqW-1:0]    origin_square,
  input  logic [cpas_pkg::BoardW-1:0] blockers,
  output logic [cpas_pkg::BoardW-1:0] attack_set
);

  logic [cpas_pkg::BoardW-1:0] one_step;
  logic [cpas_pkg::BoardW-1:0] two_step;
  logic [cpas_pkg::BoardW-1:0] knight;
  logic [cpas_pkg::BoardW-1:0] king_side;
  logic [cpas_pkg::BoardW-1:0] king_row;
  logic [cpas_pkg::BoardW-1:0] king;
  logic [cpas_pkg::BoardW-1:0] diag;
  logic [cpas_pkg::BoardW-1:0] orth;

  assign one_step = ((piece_set >> 1) & cpas_pkg::NOT_FILE_H)
                  | ((piece_set << 1) & cpas_pkg::NOT_FILE_A);
  assign two_step = ((piece_set >> 2) & cpas_pkg::NOT_FILE_GH)
                  | ((piece_set << 2) & cpas_pkg::NOT_FILE_AB);
  assign knight   = (one_step << 16) | (one_step >> 16) | (two_step << 8) | (two_step >> 8);

  assign king_side = one_step;
  assign king_row  = piece_set | king_side;
  assign king      = king_side | (king_row << 8) | (king_row >> 8);

  // rays walk up to seven squares, stopping after the first blocker
  always_comb begin
    logic signed [4:0]           r;
    logic signed [4:0]           f;
    logic                        open;
    logic [cpas_pkg::SqW-1:0]    sq;
    diag = '0;
    orth = '0;
    for (int d = 0; d < cpas_pkg::NumDirs; d++) begin
      r    = {2'b00, origin_square[5:3]};
      f    = {2'b00, origin_square[2:0]};
      open = 1'b1;
      for (int k = 0; k < cpas_pkg::RayLen; k++) begin
        r  = r + {{3{cpas_pkg::RAY_DR[d][1]}}, cpas_pkg::RAY_DR[d]};
        f  = f + {{3{cpas_pkg::RAY_DF[d][1]}}, cpas_pkg::RAY_DF[d]};
        sq = {r[2:0], f[2:0]};
        if (open && (r[4:3] == 2'b00) && (f[4:3] == 2'b00)) begin
          if (d < cpas_pkg::NumDirs / 2) begin
            diag[sq] = 1'b1;
          end else begin
            orth[sq] = 1'b1;
          end
          if (blockers[sq]) begin
            open = 1'b0;
          end
        end else begin
          open = 1'b0;
        end
      end
    end
  end

  always_comb begin
    unique case (mode)
      cpas_pkg::MODE_KNIGHT: attack_set = knight;
      cpas_pkg::MODE_KING:   attack_set = king;
      cpas_pkg::MODE_BISHOP: attack_set = diag;
      cpas_pkg::MODE_ROOK:   attack_set = orth;
      default:               attack_set = '0;
    endcase
  end

endmodule
